### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sorted list design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SLID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define SLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared constants, codes and control types for the sorted list design.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the captured operation to the store
    } dp_cmd_t;

endpackage

### rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded store of signed 8-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// The input channel takes one word per item: an operation (insert or
// delete) and a signed value. An insert places the value ahead of the first
// stored value that is not smaller than it; a delete removes the first
// stored value equal to it. The output channel returns one word per item:
// a status code and the number of values stored afterward.
// A result follows every accepted word: the accepting edge captures the
// word, every cell compares and shifts in parallel in the next cycle,
// and the edge that ends it loads the result register. The block works
// on one item at a time, so a new word is taken only once the result of
// the last one is delivered, which a stalled receiver holds back.
// When the receiver stalls, the result holds steady and no new word is
// taken until it is delivered. Reset empties the store and clears the
// controller; the stored values themselves are not cleared, as cells above
// the count are never read.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic signed [slid_pkg::VAL_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slid_pkg::STATUS_W-1:0]     status,
    output logic [slid_pkg::COUNT_W-1:0]      count
);
    import slid_pkg::*;

`include "assert_macros.svh"

    dp_cmd_t cmd;

    // The controller sequences the handshake and issues commands.
    slid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the store, the count and the result register.
    slid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (operation),
        .value     (value),
        .status    (status),
        .count     (count)
    );

    // A pending result blocks new words.
    `SLID_ASSERT_NOW(a_busy_when_done, clk, rst_n, out_valid, !in_ready,
        "input ready while a result is pending")

    // An accepted word is never followed at once by another.
    `SLID_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
        "second word taken right after an accepted word")

    // A dropped insert only happens with the store at capacity.
    `SLID_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (status == ST_FULL),
        count == COUNT_W'(CAPACITY), "full status with a count below capacity")

    // An empty report always comes with a zero count.
    `SLID_ASSERT_NOW(a_empty_count, clk, rst_n, out_valid && (status == ST_EMPTY),
        count == '0, "empty status with a nonzero count")

endmodule

### rtl/slid_ctrl.sv
// ----------------------------------------------------------------------------
// slid_ctrl
// Handshake controller: accept a word, run it once, hold the result.
// ----------------------------------------------------------------------------
module slid_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output slid_pkg::dp_cmd_t cmd
);
    import slid_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign cmd.load  = in_valid && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC);

endmodule

### rtl/slid_dp.sv
// ----------------------------------------------------------------------------
// slid_dp
// Sorted store of signed values with per-cell compare and shift.
// ----------------------------------------------------------------------------
module slid_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  slid_pkg::dp_cmd_t              cmd,
    input  logic                           operation,
    input  logic signed [slid_pkg::VAL_W-1:0] value,
    output logic [slid_pkg::STATUS_W-1:0]  status,
    output logic [slid_pkg::COUNT_W-1:0]   count
);
    import slid_pkg::*;

    logic                    op_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;

    logic                    live    [CAPACITY];
    logic                    gt      [CAPACITY];
    logic                    past    [CAPACITY];
    logic signed [VAL_W-1:0] ins_val [CAPACITY];
    logic signed [VAL_W-1:0] del_val [CAPACITY];
    logic                    full;
    logic                    empty;
    logic                    found;
    logic                    do_ins;
    logic                    do_del;

    // Every cell compares against the captured value at once. Cells below
    // the insert point hold, the insert point takes the value, and the rest
    // shift up by one. On delete, the first match and everything above it
    // pull from the next cell up.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live[i] = (CNT_W'(i) < count_reg);
            gt[i]   = live[i] && (value_reg > entries_reg[i]);
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                past[i] = live[i] && (entries_reg[i] == value_reg);
            end
            else
            begin
                past[i] = past[i-1] || (live[i] && (entries_reg[i] == value_reg));
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (gt[i])
            begin
                ins_val[i] = entries_reg[i];
            end
            else if (i == 0)
            begin
                ins_val[i] = value_reg;
            end
            else if (gt[i-1])
            begin
                ins_val[i] = value_reg;
            end
            else
            begin
                ins_val[i] = entries_reg[i-1];
            end
            if (i < CAPACITY - 1 && past[i])
            begin
                del_val[i] = entries_reg[i+1];
            end
            else
            begin
                del_val[i] = entries_reg[i];
            end
        end
    end

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign found  = past[CAPACITY-1];
    assign do_ins = cmd.exec && (op_reg == OP_INSERT) && !full;
    assign do_del = cmd.exec && (op_reg == OP_DELETE) && found;

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
        status_reg <= status_next;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (do_ins)
            begin
                entries_reg[i] <= ins_val[i];
            end
            else if (do_del)
            begin
                entries_reg[i] <= del_val[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign status = status_reg;
    assign count  = COUNT_W'(count_reg);

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for sorted_list_insert_delete
// Drives insert and delete words through the valid/ready input channel,
// predicts every status and count from a queue-based copy of the sorted
// store, and checks each result word in order under varied back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import slid_pkg::*;

    typedef logic signed [VAL_W-1:0] entry_t;

    // The expected result for one accepted word.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } outcome_t;

    // Guard against a hung handshake. The slowest legal run is a few
    // hundred words, each slowed by heavy stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Length of the long receiver hold-off that forces the block to fill.
    localparam int HOLD_CYCLES = 60;
    // Cycles to wait after the last result.
    localparam int DRAIN_CYCLES = 12;

    // Scoreboard: keeps its own sorted copy of the store, works out the
    // result of every accepted word, and compares result words in order.
    class sorted_store_book;
        entry_t   cells[$];
        outcome_t awaited[$];
        int       errors;
        int       tally[4];
        int       peak;
        int       checked;

        // Apply one accepted word to the shadow store.
        function void note_word(logic op, entry_t val);
            outcome_t res;
            int       pos;
            pos = 0;
            if (op == OP_INSERT) begin
                if (cells.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end
                else begin
                    // The new value goes ahead of the first entry not below it.
                    while (pos < cells.size() && val > cells[pos])
                        pos++;
                    cells.insert(pos, val);
                    res.status = ST_OK;
                end
            end
            else begin
                if (cells.size() == 0) begin
                    res.status = ST_EMPTY;
                end
                else begin
                    while (pos < cells.size() && cells[pos] != val)
                        pos++;
                    if (pos >= cells.size()) begin
                        res.status = ST_NOT_FOUND;
                    end
                    else begin
                        cells.delete(pos);
                        res.status = ST_OK;
                    end
                end
            end
            res.count = COUNT_W'(cells.size());
            if (cells.size() > peak)
                peak = cells.size();
            tally[res.status]++;
            awaited.push_back(res);
        endfunction

        // Compare one delivered result word with the oldest expectation.
        function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
            outcome_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: status %0d count %0d",
                         $time, st, cnt);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (st !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, st);
            end
            if (cnt !== want.count) begin
                errors++;
                $display("%0t: count mismatch: expected %0d actual %0d",
                         $time, want.count, cnt);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int stored();
            return cells.size();
        endfunction

        // A value currently held, so that deletes often hit.
        function entry_t pick_stored();
            return cells[$urandom_range(cells.size() - 1)];
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   operation = OP_INSERT;
    entry_t value     = '0;
    logic   out_ready = 1'b0;

    logic                in_ready;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    sorted_store_book book = new;

    // Idle rates in percent; the sender's is used by the main process only,
    // the receiver's is handed over with a nonblocking write.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // The main process bumps this to ask the receiver for one long hold-off.
    int hold_asked    = 0;
    int words_sent    = 0;
    int cycles        = 0;

    sorted_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count     (count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Timeout. A correct run finishes far below this limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycles, book.pending());
            $display("FAIL sorted_list_insert_delete");
            $finish;
        end
    end

    // Result monitor. Values read here are those from just before the edge,
    // so the check does not depend on the order of processes at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(status, count);
    end

    // Receiver. Each cycle it is ready or not at the current idle rate.
    // When asked, it holds ready low for a long stretch, counting the
    // cycles itself, so that the sender backs up against a full block.
    initial
    begin
        int hold_done;
        hold_done = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_asked != hold_done) begin
                hold_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word and wait until it is taken. Valid is only lowered
    // when an idle gap comes, so it is never dropped and raised in the same
    // step; the scoreboard notes the word at the edge that accepts it.
    task automatic send_word(input logic op, input entry_t val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_word(op, val);
        words_sent++;
    endtask

    // Random words. The mix of inserts and deletes changes every twenty
    // words between mostly inserts, even and mostly deletes, so the store
    // swings between empty and full again and again. Many values come from
    // a narrow band to make duplicates, and many deletes name a value that
    // is actually stored so that the shifting paths are exercised.
    task automatic run_random(input int n);
        int     lean;
        logic   op;
        entry_t val;
        lean = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 20 == 0) begin
                case ($urandom_range(2))
                    0:       lean = 88;
                    1:       lean = 50;
                    default: lean = 12;
                endcase
            end
            op = ($urandom_range(99) < lean) ? OP_INSERT : OP_DELETE;
            if (op == OP_DELETE && book.stored() != 0 && $urandom_range(99) < 60) begin
                val = book.pick_stored();
            end
            else begin
                case ($urandom_range(9))
                    0, 1, 2, 3: val = entry_t'(int'($urandom_range(8)) - 4);
                    4:          val = $urandom_range(1) ? entry_t'(127) : entry_t'(-128);
                    default:    val = entry_t'($urandom_range(255));
                endcase
            end
            send_word(op, val);
        end
    endtask

    // Main sequence: reset, directed words, three random phases with
    // different idle patterns, then drain and report.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words. A delete on the empty store reports empty; the
        // field extremes and a duplicate go in; an absent value is missed;
        // stored values come out from the middle and both ends; the store
        // is then filled and one more insert is dropped as full.
        send_word(OP_DELETE, entry_t'(0));
        send_word(OP_INSERT, entry_t'(127));
        send_word(OP_INSERT, entry_t'(-128));
        send_word(OP_INSERT, entry_t'(0));
        send_word(OP_INSERT, entry_t'(-1));
        send_word(OP_INSERT, entry_t'(0));
        send_word(OP_INSERT, entry_t'(1));
        send_word(OP_INSERT, entry_t'(-127));
        send_word(OP_INSERT, entry_t'(126));
        send_word(OP_DELETE, entry_t'(55));
        send_word(OP_DELETE, entry_t'(0));
        send_word(OP_DELETE, entry_t'(-128));
        send_word(OP_DELETE, entry_t'(127));
        for (int k = 0; k < 11; k++)
            send_word(OP_INSERT, entry_t'(k * 23 - 120));
        send_word(OP_INSERT, entry_t'(5));

        // Sender idles rarely, receiver often.
        send_idle_pct = 11;
        recv_idle_pct <= 73;
        run_random(150);

        // Sender idles often, receiver rarely.
        send_idle_pct = 73;
        recv_idle_pct <= 11;
        run_random(150);

        // No idling on either side. A long receiver hold-off comes first,
        // while the sender keeps offering words against the stalled block.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_asked <= hold_asked + 1;
        run_random(150);
        in_valid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words, checked %0d results: %0d ok, %0d full, %0d not found,",
                 words_sent, book.checked, book.tally[ST_OK], book.tally[ST_FULL],
                 book.tally[ST_NOT_FOUND]);
        $display("%0d empty; the store held at most %0d values; %0d mismatches.",
                 book.tally[ST_EMPTY], book.peak, book.errors);
        if (book.errors == 0 && book.pending() == 0)
            $display("PASS sorted_list_insert_delete");
        else
            $display("FAIL sorted_list_insert_delete");
        $finish;
    end

endmodule
